@@ sv/plws_pkg.sv @@
// ----------------------------------------------------------------------------
// plws_pkg
// Shared types and constants for the piecewise-linear waveform source.
// ----------------------------------------------------------------------------
package plws_pkg;

    localparam int DEFAULT_MAX_SEGMENTS = 16;

    localparam int DUR_W   = 31;   // segment duration
    localparam int VAL_W   = 24;   // segment start / end value
    localparam int TIME_W  = 32;   // evaluation time
    localparam int IDX_W   = 4;    // segment index field
    localparam int GAIN_W  = 32;
    localparam int OUT_W   = 32;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 32'h0001_0000;

    // tdata layouts, lowest bit first
    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 40;

    // RAM word: {end, start, duration}
    localparam int SEG_WORD_W = DUR_W + 2 * VAL_W;

    typedef enum logic [1:0] {
        REG_GAIN        = 2'd0,
        REG_OFFSET      = 2'd1,
        REG_WRAP_BEFORE = 2'd2,
        REG_WRAP_AFTER  = 2'd3
    } reg_idx_t;

    typedef enum logic {
        FUNC_EVAL = 1'b0,
        FUNC_LOAD = 1'b1
    } func_t;

    typedef enum logic {
        STATUS_EVAL = 1'b0,
        STATUS_LOAD = 1'b1
    } status_t;

endpackage

@@ sv/plws_ram.sv @@
// ----------------------------------------------------------------------------
// plws_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module plws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/piecewise_linear_waveform_source_top.sv @@
// ----------------------------------------------------------------------------
// piecewise_linear_waveform_source_top
// Segment table with wrap/clamp time mapping, interpolation, gain and offset.
// ----------------------------------------------------------------------------
// One request at a time. An evaluation makes two passes over the segment RAM
// (one read per cycle, registered read data) and one run of the shared
// radix-2 divider for the interpolation (56 steps). A time that is wrapped
// needs a second divider run for the modulo. The result sits in an output
// register, so the next request is taken while it waits; a new result
// stalls only while the previous one is still unaccepted. The segment table
// reads as zero after reset through per-entry valid bits; no clearing pass
// is needed.
module piecewise_linear_waveform_source_top
    import plws_pkg::*;
#(
    parameter int MAX_SEGMENTS = DEFAULT_MAX_SEGMENTS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // seg_index[3:0], seg_duration[34:4], seg_start[58:35], seg_end[82:59],
    // time_in[114:83], zero fill
    input  logic [S_TDATA_W-1:0] s_tdata,
    // func[0]
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // value_out[31:0], active_segment[35:32], zero fill
    output logic [M_TDATA_W-1:0] m_tdata,
    // status[0]
    output logic                 m_tuser,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int SW    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int PER_W = DUR_W + $clog2(MAX_SEGMENTS + 1);
    localparam int NUM_W = VAL_W + 1 + DUR_W;
    localparam int P1_W  = VAL_W + 1 + TIME_W;
    localparam int V_W   = VAL_W + 2;
    localparam int P2_W  = V_W + GAIN_W;
    localparam int SH_W  = P2_W - 16;
    localparam int SUM_W = SH_W + 1;

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_SUM  = 12'b0000_0000_0010,
        S_ADJ  = 12'b0000_0000_0100,
        S_MODN = 12'b0000_0000_1000,
        S_MODP = 12'b0000_0001_0000,
        S_FIND = 12'b0000_0010_0000,
        S_MUL1 = 12'b0000_0100_0000,
        S_IDIV = 12'b0000_1000_0000,
        S_VSUM = 12'b0001_0000_0000,
        S_MUL2 = 12'b0010_0000_0000,
        S_FIN  = 12'b0100_0000_0000,
        S_OUT  = 12'b1000_0000_0000
    } state_t;

    // ---------------- configuration ----------------
    logic signed [GAIN_W-1:0] gain_reg;
    logic signed [VAL_W-1:0]  offset_reg;
    logic                     wrap_before_reg;
    logic                     wrap_after_reg;
    logic                     cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg        <= GAIN_RESET;
            offset_reg      <= '0;
            wrap_before_reg <= 1'b0;
            wrap_after_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(paddr[3:2]))
                REG_GAIN:        gain_reg        <= pwdata;
                REG_OFFSET:      offset_reg      <= pwdata[VAL_W-1:0];
                REG_WRAP_BEFORE: wrap_before_reg <= pwdata[0];
                REG_WRAP_AFTER:  wrap_after_reg  <= pwdata[0];
                default:         gain_reg        <= gain_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[3:2]))
            REG_GAIN:        prdata = gain_reg;
            REG_OFFSET:      prdata = {8'd0, offset_reg};
            REG_WRAP_BEFORE: prdata = {31'd0, wrap_before_reg};
            REG_WRAP_AFTER:  prdata = {31'd0, wrap_after_reg};
            default:         prdata = '0;
        endcase
    end

    // ---------------- input fields ----------------
    logic [IDX_W-1:0]         in_idx;
    logic [DUR_W-1:0]         in_dur;
    logic [VAL_W-1:0]         in_start;
    logic [VAL_W-1:0]         in_end;
    logic [TIME_W-1:0]        in_time;
    logic                     s_acc;
    logic                     ld_ok;

    assign in_idx   = s_tdata[3:0];
    assign in_dur   = s_tdata[34:4];
    assign in_start = s_tdata[58:35];
    assign in_end   = s_tdata[82:59];
    assign in_time  = s_tdata[114:83];
    assign s_acc    = s_tvalid && s_tready;
    assign ld_ok    = 32'(in_idx) < MAX_SEGMENTS;

    // ---------------- state ----------------
    state_t                   state_reg, state_next;
    logic [MAX_SEGMENTS-1:0]  vld_reg, vld_next;
    logic                     vq_reg, vq_next;
    logic [SW:0]              cnt_reg, cnt_next;
    logic                     pv_reg, pv_next;
    logic [SW:0]              pidx_reg, pidx_next;
    logic [SW:0]              n_reg, n_next;
    logic [PER_W-1:0]         period_reg, period_next;
    logic [PER_W-1:0]         acc_reg, acc_next;
    logic [TIME_W-1:0]        t_reg, t_next;
    logic [PER_W-1:0]         tadj_reg, tadj_next;
    logic [SW-1:0]            seg_reg, seg_next;
    logic [PER_W-1:0]         begin_reg, begin_next;
    logic [DUR_W-1:0]         dur_reg, dur_next;
    logic signed [VAL_W-1:0]  vs_reg, vs_next;
    logic signed [VAL_W-1:0]  ve_reg, ve_next;
    logic                     neg_reg, neg_next;
    logic [NUM_W-1:0]         dn_reg, dn_next;
    logic [PER_W-1:0]         dr_reg, dr_next;
    logic [PER_W-1:0]         dd_reg, dd_next;
    logic [6:0]               dc_reg, dc_next;
    logic signed [V_W-1:0]    v_reg, v_next;
    logic signed [P2_W-1:0]   p2_reg, p2_next;
    logic [OUT_W-1:0]         rv_reg, rv_next;
    logic [IDX_W-1:0]         rs_reg, rs_next;
    logic                     rst_reg, rst_next;
    logic                     mv_reg, mv_next;
    logic [OUT_W-1:0]         mval_reg, mval_next;
    logic [IDX_W-1:0]         mseg_reg, mseg_next;
    logic                     mst_reg, mst_next;

    // ---------------- segment RAM ----------------
    logic                     ram_we;
    logic [SW-1:0]            ram_waddr;
    logic [SEG_WORD_W-1:0]    ram_wdata;
    logic [SW-1:0]            ram_raddr;
    logic [SEG_WORD_W-1:0]    ram_rdata;

    assign ram_we    = s_acc && (s_tuser == FUNC_LOAD) && ld_ok;
    assign ram_waddr = SW'(in_idx);
    assign ram_wdata = {in_end, in_start, in_dur};
    assign ram_raddr = cnt_reg[SW-1:0];

    plws_ram #(
        .WIDTH (SEG_WORD_W),
        .DEPTH (MAX_SEGMENTS)
    ) u_seg_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // entry seen this cycle; never-written entries read as zero
    logic [DUR_W-1:0]         rd_len;
    logic [DUR_W-1:0]         eff_len;
    logic signed [VAL_W-1:0]  rd_start;
    logic signed [VAL_W-1:0]  rd_end;
    logic                     last_entry;

    assign rd_len   = vq_reg ? ram_rdata[DUR_W-1:0] : '0;
    assign rd_start = vq_reg ? ram_rdata[DUR_W+VAL_W-1:DUR_W] : '0;
    assign rd_end   = vq_reg ? ram_rdata[SEG_WORD_W-1:DUR_W+VAL_W] : '0;
    assign eff_len  = (pidx_reg == '0 && rd_len == '0) ? DUR_W'(1) : rd_len;
    assign last_entry = (32'(pidx_reg) == MAX_SEGMENTS - 1);

    // ---------------- divider step ----------------
    logic [PER_W:0]           d_trial;
    logic                     d_ge;
    logic [PER_W:0]           d_sub;

    assign d_trial = {dr_reg, dn_reg[NUM_W-1]};
    assign d_ge    = d_trial >= {1'b0, dd_reg};
    assign d_sub   = d_trial - {1'b0, dd_reg};

    // ---------------- datapath helpers ----------------
    logic [TIME_W-1:0]        t_mag;
    logic [PER_W-1:0]         t_pos;
    logic [DUR_W-1:0]         elapsed;
    logic signed [VAL_W:0]    diff;
    logic signed [TIME_W-1:0] el_s;
    logic signed [P1_W-1:0]   prod1;
    logic [P1_W-1:0]          prod1_mag;
    logic signed [V_W-1:0]    q_s;
    logic signed [SH_W-1:0]   shifted;
    logic signed [SUM_W-1:0]  total;

    assign t_mag     = TIME_W'(-{t_reg[TIME_W-1], t_reg});
    assign t_pos     = PER_W'(t_reg[TIME_W-2:0]);
    assign elapsed   = DUR_W'(tadj_reg - begin_reg);
    assign diff      = {ve_reg[VAL_W-1], ve_reg} - {vs_reg[VAL_W-1], vs_reg};
    assign el_s      = {1'b0, elapsed};
    assign prod1     = diff * el_s;
    assign prod1_mag = prod1[P1_W-1] ? P1_W'(-prod1) : P1_W'(prod1);
    assign shifted   = p2_reg[P2_W-1:16];
    assign total     = SUM_W'(shifted) + SUM_W'(offset_reg);

    always_comb
    begin
        if (neg_reg)
        begin
            if (dr_reg != '0)
                q_s = -V_W'(dn_reg[VAL_W:0]) - V_W'(1);
            else
                q_s = -V_W'(dn_reg[VAL_W:0]);
        end
        else
        begin
            q_s = V_W'(dn_reg[VAL_W:0]);
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    // ---------------- control ----------------
    always_comb
    begin
        state_next  = state_reg;
        vld_next    = vld_reg;
        vq_next     = 1'b0;
        cnt_next    = cnt_reg;
        pv_next     = 1'b0;
        pidx_next   = cnt_reg;
        n_next      = n_reg;
        period_next = period_reg;
        acc_next    = acc_reg;
        t_next      = t_reg;
        tadj_next   = tadj_reg;
        seg_next    = seg_reg;
        begin_next  = begin_reg;
        dur_next    = dur_reg;
        vs_next     = vs_reg;
        ve_next     = ve_reg;
        neg_next    = neg_reg;
        dn_next     = dn_reg;
        dr_next     = dr_reg;
        dd_next     = dd_reg;
        dc_next     = dc_reg;
        v_next      = v_reg;
        p2_next     = p2_reg;
        rv_next     = rv_reg;
        rs_next     = rs_reg;
        rst_next    = rst_reg;
        mv_next     = mv_reg;
        mval_next   = mval_reg;
        mseg_next   = mseg_reg;
        mst_next    = mst_reg;

        if (mv_reg && m_tready)
            mv_next = 1'b0;

        // RAM read issue shared by both table walks
        if ((state_reg == S_SUM || state_reg == S_FIND) && 32'(cnt_reg) < MAX_SEGMENTS)
        begin
            vq_next  = vld_reg[ram_raddr];
            pv_next  = 1'b1;
            cnt_next = cnt_reg + 1'b1;
        end

        // divider runs whenever its counter is nonzero
        if (dc_reg != '0)
        begin
            dc_next = dc_reg - 1'b1;
            dr_next = d_ge ? PER_W'(d_sub) : PER_W'(d_trial);
            dn_next = {dn_reg[NUM_W-2:0], d_ge};
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_acc)
                begin
                    if (s_tuser == FUNC_LOAD)
                    begin
                        if (ld_ok)
                            vld_next[ram_waddr] = 1'b1;
                        rv_next    = '0;
                        rs_next    = in_idx;
                        rst_next   = STATUS_LOAD;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        t_next      = in_time;
                        cnt_next    = '0;
                        period_next = '0;
                        state_next  = S_SUM;
                    end
                end
            end

            S_SUM:
            begin
                if (pv_reg)
                begin
                    if (eff_len == '0)
                    begin
                        n_next     = pidx_reg;
                        state_next = S_ADJ;
                    end
                    else
                    begin
                        period_next = period_reg + PER_W'(eff_len);
                        n_next      = pidx_reg + 1'b1;
                        if (last_entry)
                            state_next = S_ADJ;
                    end
                end
            end

            S_ADJ:
            begin
                if (t_reg[TIME_W-1])
                begin
                    if (wrap_before_reg)
                    begin
                        dn_next    = NUM_W'(t_mag);
                        dr_next    = '0;
                        dd_next    = period_reg;
                        dc_next    = 7'(NUM_W);
                        state_next = S_MODN;
                    end
                    else
                    begin
                        tadj_next  = '0;
                        state_next = S_FIND;
                    end
                end
                else if (t_pos > period_reg)
                begin
                    if (wrap_after_reg)
                    begin
                        dn_next    = NUM_W'(t_reg);
                        dr_next    = '0;
                        dd_next    = period_reg;
                        dc_next    = 7'(NUM_W);
                        state_next = S_MODP;
                    end
                    else
                    begin
                        tadj_next  = period_reg;
                        state_next = S_FIND;
                    end
                end
                else
                begin
                    tadj_next  = t_pos;
                    state_next = S_FIND;
                end
                cnt_next = '0;
                acc_next = '0;
            end

            S_MODN:
            begin
                if (dc_reg == '0)
                begin
                    tadj_next  = (dr_reg == '0) ? '0 : period_reg - dr_reg;
                    state_next = S_FIND;
                end
            end

            S_MODP:
            begin
                if (dc_reg == '0)
                begin
                    tadj_next  = dr_reg;
                    state_next = S_FIND;
                end
            end

            S_FIND:
            begin
                if (pv_reg)
                begin
                    if (acc_reg <= tadj_reg)
                    begin
                        seg_next   = pidx_reg[SW-1:0];
                        begin_next = acc_reg;
                        dur_next   = eff_len;
                        vs_next    = rd_start;
                        ve_next    = rd_end;
                    end
                    acc_next = acc_reg + PER_W'(eff_len);
                    if (pidx_reg + 1'b1 == n_reg)
                        state_next = S_MUL1;
                end
            end

            S_MUL1:
            begin
                neg_next   = prod1[P1_W-1];
                dn_next    = NUM_W'(prod1_mag);
                dr_next    = '0;
                dd_next    = PER_W'(dur_reg);
                dc_next    = 7'(NUM_W);
                state_next = S_IDIV;
            end

            S_IDIV:
            begin
                if (dc_reg == '0)
                    state_next = S_VSUM;
            end

            S_VSUM:
            begin
                v_next     = V_W'(vs_reg) + q_s;
                state_next = S_MUL2;
            end

            S_MUL2:
            begin
                p2_next    = v_reg * gain_reg;
                state_next = S_FIN;
            end

            S_FIN:
            begin
                if (total > SUM_W'(32'sh7FFF_FFFF))
                    rv_next = 32'h7FFF_FFFF;
                else if (total < -SUM_W'(33'sh0_8000_0000))
                    rv_next = 32'h8000_0000;
                else
                    rv_next = total[OUT_W-1:0];
                rs_next    = IDX_W'(seg_reg);
                rst_next   = STATUS_EVAL;
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (!mv_reg || m_tready)
                begin
                    mv_next    = 1'b1;
                    mval_next  = rv_reg;
                    mseg_next  = rs_reg;
                    mst_next   = rst_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            vld_reg   <= '0;
            vq_reg    <= 1'b0;
            cnt_reg   <= '0;
            pv_reg    <= 1'b0;
            dc_reg    <= '0;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            vld_reg   <= vld_next;
            vq_reg    <= vq_next;
            cnt_reg   <= cnt_next;
            pv_reg    <= pv_next;
            dc_reg    <= dc_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg   <= pidx_next;
        n_reg      <= n_next;
        period_reg <= period_next;
        acc_reg    <= acc_next;
        t_reg      <= t_next;
        tadj_reg   <= tadj_next;
        seg_reg    <= seg_next;
        begin_reg  <= begin_next;
        dur_reg    <= dur_next;
        vs_reg     <= vs_next;
        ve_reg     <= ve_next;
        neg_reg    <= neg_next;
        dn_reg     <= dn_next;
        dr_reg     <= dr_next;
        dd_reg     <= dd_next;
        v_reg      <= v_next;
        p2_reg     <= p2_next;
        rv_reg     <= rv_next;
        rs_reg     <= rs_next;
        rst_reg    <= rst_next;
        mval_reg   <= mval_next;
        mseg_reg   <= mseg_next;
        mst_reg    <= mst_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {4'd0, mseg_reg, mval_reg};
    assign m_tuser  = mst_reg;

endmodule
